[hdl/fqp_pkg.sv]
// ----------------------------------------------------------------------------
// fqp_pkg
// Shared types and constants of the FASTQ record parser: record phases,
// the classified byte token and the queue geometry.
// ----------------------------------------------------------------------------
package fqp_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int REC_LEN_W       = 16;
	localparam int LEN_EXT_W       = 32;
	localparam int BYTE_W          = 8;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
	localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_GR_LO   = 8'h21;
	localparam logic [BYTE_W-1:0] CH_GR_HI   = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_QUAL_HI = 8'h7F;

	localparam logic [2:0] ADDR_SHARD_IS_FIRST = 3'h0;

	typedef enum logic [2:0] {
		PH_SEARCH  = 3'd0,
		PH_NAME    = 3'd1,
		PH_COMMENT = 3'd2,
		PH_SEQ     = 3'd3,
		PH_PLUS    = 3'd4,
		PH_QUAL    = 3'd5
	} phase_t;

	typedef enum logic {
		KIND_BASE    = 1'b0,
		KIND_REC_END = 1'b1
	} kind_t;

	typedef enum logic {
		ST_OK        = 1'b0,
		ST_QUAL_BAD  = 1'b1
	} status_t;

	// one byte of the stream with its classification
	typedef struct packed {
		logic              is_end;
		logic [BYTE_W-1:0] data;
		logic              at;
		logic              plus;
		logic              nl;
		logic              white;
		logic              graphic;
		logic              qual;
	} tok_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

[hdl/fqp_front.sv]
// ----------------------------------------------------------------------------
// fqp_front
// Input side: takes byte transactions while the queue has room and tags
// each byte with its character class.
// ----------------------------------------------------------------------------
module fqp_front (
	input  logic                    in_valid,
	input  logic [7:0]              data_byte,
	input  logic                    is_end,
	input  fqp_pkg::q_status_t      q_stat,
	output logic                    in_stall,
	output logic                    push,
	output fqp_pkg::tok_t           tok
);
	import fqp_pkg::*;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		tok.is_end  = is_end;
		tok.data    = data_byte;
		tok.at      = (data_byte == CH_AT);
		tok.plus    = (data_byte == CH_PLUS);
		tok.nl      = (data_byte == CH_NL);
		tok.white   = (data_byte == CH_SPACE) ||
			((data_byte >= CH_TAB) && (data_byte <= CH_CR));
		tok.graphic = (data_byte >= CH_GR_LO) && (data_byte <= CH_GR_HI);
		tok.qual    = (data_byte >= CH_GR_LO) && (data_byte <= CH_QUAL_HI);
	end

endmodule

[hdl/fqp_queue.sv]
// ----------------------------------------------------------------------------
// fqp_queue
// Short token queue between the classifier and the phase engine so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module fqp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  fqp_pkg::tok_t           push_tok,
	input  logic                    pop,
	output fqp_pkg::tok_t           head_tok,
	output fqp_pkg::q_status_t      q_stat
);
	import fqp_pkg::*;

	tok_t                 slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_tok     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/fqp_back.sv]
// ----------------------------------------------------------------------------
// fqp_back
// Phase engine: walks the record phases one token per cycle while its output
// slot is free, keeps base and quality counts, drives the registered result.
// ----------------------------------------------------------------------------
module fqp_back #(
	parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shard_is_first,
	input  fqp_pkg::tok_t           head_tok,
	input  fqp_pkg::q_status_t      q_stat,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    kind,
	output logic [7:0]              base_byte,
	output logic [15:0]             record_length,
	output logic                    status
);
	import fqp_pkg::*;

	localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

	phase_t                  phase_q, phase_d;
	logic                    newline_seen_q, newline_seen_d;
	logic                    first_found_q, first_found_d;
	logic [LENGTH_BITS-1:0]  base_count_q, base_count_d;
	logic [LENGTH_BITS-1:0]  quality_count_q, quality_count_d;

	logic                    out_valid_q;
	logic                    kind_q;
	logic [BYTE_W-1:0]       base_byte_q;
	logic [REC_LEN_W-1:0]    record_length_q;
	logic                    status_q;

	logic                    slot_free;
	logic                    emit;
	kind_t                   emit_kind;
	logic [BYTE_W-1:0]       emit_byte;
	logic                    emit_len_sel;
	status_t                 emit_status;
	logic [LEN_EXT_W-1:0]    bc_ext;
	logic [REC_LEN_W-1:0]    len_sat;
	logic                    counts_eq;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = slot_free && !q_stat.empty;

	assign bc_ext    = LEN_EXT_W'(base_count_q);
	assign len_sat   = (bc_ext > LEN_EXT_W'(16'hFFFF)) ? 16'hFFFF : bc_ext[REC_LEN_W-1:0];
	assign counts_eq = (quality_count_q == base_count_q);

	always_comb begin
		phase_d         = phase_q;
		newline_seen_d  = newline_seen_q;
		first_found_d   = first_found_q;
		base_count_d    = base_count_q;
		quality_count_d = quality_count_q;
		emit            = 1'b0;
		emit_kind       = KIND_REC_END;
		emit_byte       = '0;
		emit_len_sel    = 1'b0;
		emit_status     = ST_OK;

		if (head_tok.is_end) begin
			phase_d        = PH_SEARCH;
			newline_seen_d = 1'b0;
			emit_len_sel   = 1'b1;
			unique case (phase_q)
				PH_NAME, PH_COMMENT, PH_SEQ: begin
					emit = 1'b1;
				end
				PH_PLUS: begin
					emit        = 1'b1;
					emit_status = ST_QUAL_BAD;
				end
				PH_QUAL: begin
					emit        = 1'b1;
					emit_status = counts_eq ? ST_OK : ST_QUAL_BAD;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_NAME: begin
					if (head_tok.white) begin
						phase_d = head_tok.nl ? PH_SEQ : PH_COMMENT;
					end
				end
				PH_COMMENT: begin
					if (head_tok.nl) begin
						phase_d = PH_SEQ;
					end
				end
				PH_SEQ: begin
					priority if (head_tok.plus) begin
						phase_d = PH_PLUS;
					end else if (head_tok.at) begin
						// '@' closes this record and opens the next
						emit            = 1'b1;
						emit_len_sel    = 1'b1;
						first_found_d   = 1'b1;
						phase_d         = PH_NAME;
						base_count_d    = '0;
						quality_count_d = '0;
					end else if (head_tok.graphic) begin
						emit      = 1'b1;
						emit_kind = KIND_BASE;
						emit_byte = head_tok.data;
						if (base_count_q != CNT_MAX) begin
							base_count_d = base_count_q + 1'b1;
						end
					end else begin
						emit = 1'b0;
					end
				end
				PH_PLUS: begin
					if (head_tok.nl) begin
						phase_d = PH_QUAL;
					end
				end
				PH_QUAL: begin
					// byte arriving with the quality line complete is dropped
					if (quality_count_q >= base_count_q) begin
						phase_d        = PH_SEARCH;
						newline_seen_d = 1'b0;
						emit           = 1'b1;
						emit_len_sel   = 1'b1;
						emit_status    = counts_eq ? ST_OK : ST_QUAL_BAD;
					end else if (head_tok.qual && (quality_count_q != CNT_MAX)) begin
						quality_count_d = quality_count_q + 1'b1;
					end
				end
				default: begin
					if (head_tok.at &&
						(shard_is_first || first_found_q || newline_seen_q)) begin
						newline_seen_d  = 1'b0;
						first_found_d   = 1'b1;
						phase_d         = PH_NAME;
						base_count_d    = '0;
						quality_count_d = '0;
					end else begin
						phase_d        = PH_SEARCH;
						newline_seen_d = head_tok.nl;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SEARCH;
			newline_seen_q  <= 1'b0;
			first_found_q   <= 1'b0;
			base_count_q    <= '0;
			quality_count_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				phase_q         <= phase_d;
				newline_seen_q  <= newline_seen_d;
				first_found_q   <= first_found_d;
				base_count_q    <= base_count_d;
				quality_count_q <= quality_count_d;
			end
			if (slot_free) begin
				out_valid_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q          <= emit_kind;
			base_byte_q     <= emit_byte;
			record_length_q <= emit_len_sel ? len_sat : '0;
			status_q        <= emit_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign base_byte     = base_byte_q;
	assign record_length = record_length_q;
	assign status        = status_q;

	// qualities are only counted while below the base count
	a_qual_le_base: assert property (@(posedge clk) disable iff (!arst_n)
		quality_count_q <= base_count_q)
		else $error("quality count passed base count");

	a_end_to_search: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_tok.is_end |=> phase_q == PH_SEARCH && !newline_seen_q)
		else $error("end mark did not return to search");

	a_first_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(first_found_q))
		else $error("first record flag cleared");

	a_base_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_BASE) |->
			record_length_q == '0 && status_q == ST_OK)
		else $error("base transaction carries record-end fields");

	a_no_emit_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(record_length_q) && $stable(base_byte_q))
		else $error("result overwritten while stalled");

endmodule

[hdl/fastq_record_parser_unit.sv]
// ----------------------------------------------------------------------------
// fastq_record_parser_unit
// FASTQ record parser: bytes in, sequence bases and record-end reports out.
// ----------------------------------------------------------------------------
// The unit takes one byte (or end-of-stream mark) per cycle while in_stall is
// low and sustains one transaction per cycle as long as the output side is
// not stalled. An accepted byte is classified and written into a four-entry
// queue; the phase engine takes it from the queue head once its result
// register is free and registers its result. The queue absorbs short output
// stalls; the input stalls only when all four entries are occupied. Each
// byte produces at most one result: a sequence base (kind 0) or a record end
// (kind 1) with the saturated sequence length and a quality status.
// shard_is_first sits at address 0 and should only be changed while no
// transaction is in flight.
module fastq_record_parser_unit #(
	parameter int LENGTH_BITS = fqp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  base_byte,
	output logic [15:0] record_length,
	output logic        status
);
	import fqp_pkg::*;

	logic       shard_is_first_q;
	logic       push;
	logic       pop;
	tok_t       in_tok;
	tok_t       head_tok;
	q_status_t  q_stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shard_is_first_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr == ADDR_SHARD_IS_FIRST)) begin
			shard_is_first_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == ADDR_SHARD_IS_FIRST) ? {31'b0, shard_is_first_q} : 32'b0;

	fqp_front u_front (
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.is_end    (is_end),
		.q_stat    (q_stat),
		.in_stall  (in_stall),
		.push      (push),
		.tok       (in_tok)
	);

	fqp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (in_tok),
		.pop      (pop),
		.head_tok (head_tok),
		.q_stat   (q_stat)
	);

	fqp_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.shard_is_first (shard_is_first_q),
		.head_tok       (head_tok),
		.q_stat         (q_stat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.base_byte      (base_byte),
		.record_length  (record_length),
		.status         (status)
	);

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FASTQ record parser. A short scripted byte
// stream walks every record phase and the end-of-stream flushes. Random
// FASTQ records with broken and noisy parts follow, under both shard modes
// and with random gaps and output stalls. Every result is compared against
// an in-bench parser that tracks the same phases and counters, or against the typed result of a script row.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fqp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 270;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct {
		kind_t       kind;
		logic [7:0]  base;
		logic [15:0] len;
		status_t     st;
	} fq_result_t;

	// how a scripted byte is checked: by the parser model or by a typed result
	typedef enum { BY_MODEL, NO_RESULT, GIVES_BASE, ENDS_OK, ENDS_BAD } row_expect_t;

	typedef struct {
		logic [7:0]  b;
		logic        e;
		row_expect_t how;
		logic [15:0] len;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        is_end;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  base_byte;
	logic [15:0] record_length;
	logic        status;

	// parser state as the block should hold it
	phase_t      ph;
	logic        nl_seen;
	logic        rec_found;
	logic        first_shard;
	logic [15:0] n_bases;
	logic [15:0] n_quals;

	fq_result_t  due_results[$];
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned idle_cycles;
	int          gap_odds;
	int          stall_odds;
	int          stall_left;
	logic        at_open;
	string       bases = "ACGTN";

	// starts under shard_is_first = 0, so the first '@' needs a newline before it
	script_row_t script [29] = '{
		'{8'h40, 1'b0, NO_RESULT,  16'd0},
		'{8'h0A, 1'b0, NO_RESULT,  16'd0},
		'{8'h40, 1'b0, NO_RESULT,  16'd0},
		'{8'h0A, 1'b0, NO_RESULT,  16'd0},
		'{8'h21, 1'b0, GIVES_BASE, 16'd0},
		'{8'h7E, 1'b0, GIVES_BASE, 16'd0},
		'{8'h7F, 1'b0, NO_RESULT,  16'd0},
		'{8'hFF, 1'b0, NO_RESULT,  16'd0},
		'{8'h40, 1'b0, ENDS_OK,    16'd2},
		'{8'h0A, 1'b0, NO_RESULT,  16'd0},
		'{8'h2B, 1'b0, NO_RESULT,  16'd0},
		'{8'h0A, 1'b0, NO_RESULT,  16'd0},
		'{8'h00, 1'b0, ENDS_OK,    16'd0},
		'{8'h00, 1'b1, NO_RESULT,  16'd0},
		'{8'h40, 1'b0, BY_MODEL,   16'd0},
		'{8'h09, 1'b0, BY_MODEL,   16'd0},
		'{8'hC3, 1'b1, ENDS_OK,    16'd0},
		'{8'h40, 1'b0, BY_MODEL,   16'd0},
		'{8'h0A, 1'b0, BY_MODEL,   16'd0},
		'{8'h47, 1'b0, BY_MODEL,   16'd0},
		'{8'h2B, 1'b0, BY_MODEL,   16'd0},
		'{8'h55, 1'b1, ENDS_BAD,   16'd1},
		'{8'h40, 1'b0, BY_MODEL,   16'd0},
		'{8'h0A, 1'b0, BY_MODEL,   16'd0},
		'{8'h43, 1'b0, BY_MODEL,   16'd0},
		'{8'h2B, 1'b0, BY_MODEL,   16'd0},
		'{8'h0A, 1'b0, BY_MODEL,   16'd0},
		'{8'h80, 1'b0, NO_RESULT,  16'd0},
		'{8'hAA, 1'b1, ENDS_BAD,   16'd1}
	};

	fastq_record_parser_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.is_end       (is_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.base_byte    (base_byte),
		.record_length(record_length),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic fq_result_t rec_end(input status_t s);
		return '{KIND_REC_END, 8'h00, n_bases, s};
	endfunction

	function automatic void start_record();
		rec_found = 1'b1;
		ph = PH_NAME;
		n_bases = '0;
		n_quals = '0;
	endfunction

	// one step of the record parser; returns 1 when the byte yields a result
	function automatic bit parse_byte(input logic [7:0] c, input logic e, output fq_result_t r);
		phase_t was;
		r = '{KIND_BASE, 8'h00, 16'h0000, ST_OK};
		was = ph;
		if (e) begin
			ph = PH_SEARCH;
			nl_seen = 1'b0;
			case (was)
				PH_NAME, PH_COMMENT, PH_SEQ: r = rec_end(ST_OK);
				PH_PLUS: r = rec_end(ST_QUAL_BAD);
				PH_QUAL: r = rec_end((n_quals == n_bases) ? ST_OK : ST_QUAL_BAD);
				default: return 1'b0;
			endcase
			return 1'b1;
		end
		case (was)
			PH_NAME: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
					ph = (c == CH_NL) ? PH_SEQ : PH_COMMENT;
			end
			PH_COMMENT: begin
				if (c == CH_NL) ph = PH_SEQ;
			end
			PH_SEQ: begin
				if (c == CH_PLUS) begin
					ph = PH_PLUS;
				end else if (c == CH_AT) begin
					// '@' closes this record and opens the next one
					r = rec_end(ST_OK);
					start_record();
					return 1'b1;
				end else if (c >= CH_GR_LO && c <= CH_GR_HI) begin
					if (n_bases != '1) n_bases++;
					r = '{KIND_BASE, c, 16'h0000, ST_OK};
					return 1'b1;
				end
			end
			PH_PLUS: begin
				if (c == CH_NL) ph = PH_QUAL;
			end
			PH_QUAL: begin
				// the byte after the last quality is swallowed by the close
				if (n_quals >= n_bases) begin
					ph = PH_SEARCH;
					nl_seen = 1'b0;
					r = rec_end((n_quals == n_bases) ? ST_OK : ST_QUAL_BAD);
					return 1'b1;
				end
				if (c >= CH_GR_LO && c <= CH_QUAL_HI && n_quals != '1) n_quals++;
			end
			default: begin
				if (c == CH_AT && (first_shard || rec_found || nl_seen)) begin
					nl_seen = 1'b0;
					start_record();
				end else begin
					ph = PH_SEARCH;
					nl_seen = (c == CH_NL);
				end
			end
		endcase
		return 1'b0;
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == CH_NL) ? 8'h78 : c;
	endfunction

	function automatic logic [7:0] junk_byte();
		if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 32));
		return 8'($urandom_range(128, 255));
	endfunction

	task automatic send_item(input logic [7:0] b, input logic e,
			input row_expect_t how = BY_MODEL, input logic [15:0] len = 16'd0);
		fq_result_t r;
		bit has;
		if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		has = parse_byte(b, e, r);
		case (how)
			BY_MODEL:   if (has) due_results.push_back(r);
			GIVES_BASE: due_results.push_back('{KIND_BASE, b, 16'h0000, ST_OK});
			ENDS_OK:    due_results.push_back('{KIND_REC_END, 8'h00, len, ST_OK});
			ENDS_BAD:   due_results.push_back('{KIND_REC_END, 8'h00, len, ST_QUAL_BAD});
			default:    ;
		endcase
		items_sent++;
	endtask

	// wait until every result is out, then let bytes without results retire
	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_shard_mode(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_SHARD_IS_FIRST;
		pwdata <= {31'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		first_shard = v;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {31'b0, v}) begin
			$error("shard_is_first readback: expected %0h, actual %0h", {31'b0, v}, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
			stall_left = $urandom_range(1, 19);
		out_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin : check_results
		fq_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0d base %0h length %0d status %0d",
					kind, base_byte, record_length, status);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					mismatches++;
				end
				if (base_byte !== want.base) begin
					$error("base_byte: expected %0h, actual %0h", want.base, base_byte);
					mismatches++;
				end
				if (record_length !== want.len) begin
					$error("record_length: expected %0d, actual %0d", want.len, record_length);
					mismatches++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int          first;
		int          seq_len;
		int          n_q;
		int          k;
		logic [7:0]  c;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		is_end <= 1'b0;
		out_stall <= 1'b0;
		stall_left = 0;
		gap_odds = 3;
		stall_odds = 3;
		at_open = 1'b0;
		mismatches = 0;
		items_sent = 0;
		idle_cycles = 0;
		ph = PH_SEARCH;
		nl_seen = 1'b0;
		rec_found = 1'b0;
		first_shard = 1'b1;
		n_bases = '0;
		n_quals = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_shard_mode(1'b0);
		foreach (script[i])
			send_item(script[i].b, script[i].e, script[i].how, script[i].len);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_shard_mode(p % 2 == 0);
			if (p == PHASES - 1) begin
				gap_odds = 0;
				stall_odds = 0;
			end else begin
				k = $urandom_range(0, 2);
				gap_odds = (k == 0) ? 0 : (k == 1) ? 3 : 12;
				k = $urandom_range(0, 2);
				stall_odds = (k == 0) ? 0 : (k == 1) ? 3 : 12;
			end

			first = items_sent;
			while (items_sent - first < PHASE_ITEMS) begin
				if ($urandom_range(0, 15) == 0) begin
					repeat ($urandom_range(1, 6))
						send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
				end
				if (!at_open) send_item(CH_AT, 1'b0);
				at_open = 1'b0;
				repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(33, 126)), 1'b0);
				if ($urandom_range(0, 2) == 0) begin
					send_item(($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13)),
						1'b0);
					repeat ($urandom_range(0, 5)) send_item(text_byte(), 1'b0);
				end
				send_item(CH_NL, 1'b0);

				seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
					: $urandom_range(0, 20);
				repeat (seq_len) begin
					k = $urandom_range(0, 19);
					if (k < 15) begin
						c = bases[$urandom_range(0, 4)];
					end else if (k < 17) begin
						c = bases[$urandom_range(0, 3)] | 8'h20;
					end else if (k < 19) begin
						c = 8'($urandom_range(33, 126));
						if (c == CH_AT || c == CH_PLUS) c = "N";
					end else begin
						c = junk_byte();
					end
					send_item(c, 1'b0);
				end

				k = $urandom_range(0, 11);
				if (k == 0) begin
					// next record starts right inside the sequence
					send_item(CH_AT, 1'b0);
					at_open = 1'b1;
				end else if (k == 1) begin
					send_item(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					send_item(CH_PLUS, 1'b0);
					repeat ($urandom_range(0, 3)) send_item(text_byte(), 1'b0);
					if ($urandom_range(0, 15) == 0) begin
						send_item(8'($urandom_range(0, 255)), 1'b1);
					end else begin
						send_item(CH_NL, 1'b0);
						n_q = ($urandom_range(0, 7) == 0) ? $urandom_range(0, seq_len) : seq_len;
						repeat (n_q) begin
							if ($urandom_range(0, 15) == 0) send_item(junk_byte(), 1'b0);
							send_item(8'($urandom_range(33, 127)), 1'b0);
						end
						// truncated qualities are cut off by the end of the stream
						if (n_q != seq_len)
							send_item(8'($urandom_range(0, 255)), 1'b1);
						else
							send_item(($urandom_range(0, 3) != 0) ? CH_NL
								: 8'($urandom_range(0, 255)), 1'b0);
					end
				end
			end
		end

		drain();
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
